@@ rtl/core/crp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crp_pkg: shared constants and types for the cube rotate / project block
// Cube vertex table, configuration register codes, stream widths and the
// status bundle of the front/back queue.
// ----------------------------------------------------------------------------
package crp_pkg;

    // default parameter values
    localparam int ANGLE_STEPS_DEF    = 360;
    localparam int TRIG_FRAC_BITS_DEF = 14;

    // field widths
    localparam int SCALE_W  = 14;
    localparam int SCREEN_W = 11;
    localparam int VERT_W   = 3;
    localparam int NVERT    = 8;
    localparam int CFG_W    = 10;
    localparam int CENTER_W = CFG_W - 1;
    localparam int CFG_ADDR_W = 2;

    // stream word widths
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 32;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SCREEN_HEIGHT = 2'd1;
    localparam logic [CFG_W-1:0]      SCREEN_RESET      = 10'd240;

    // camera distance along z
    localparam int Z_OFFSET = 150;

    // quotient bits of the projection divide (result magnitude stays below 2^11)
    localparam int QUOT_W = SCREEN_W;

    // cube corners: bit i set means coordinate of vertex i is -1, else +1
    localparam logic [NVERT-1:0] CUBE_X_NEG = 8'b1001_1001;
    localparam logic [NVERT-1:0] CUBE_Y_NEG = 8'b0011_0011;
    localparam logic [NVERT-1:0] CUBE_Z_NEG = 8'b0000_1111;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic can_push;
        logic has_data;
    } crp_qstat_t;

endpackage
`default_nettype wire

@@ rtl/core/crp_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crp_fifo: short queue between front and back
// Holds looked-up frame words (sin, cos, scale) so front and back stall
// independently.
// ----------------------------------------------------------------------------
module crp_fifo #(
    parameter int DW = 32
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire logic [DW-1:0]     push_data,
    input  wire logic              pop,
    output crp_pkg::crp_qstat_t    stat,
    output logic [DW-1:0]          pop_data
);
    import crp_pkg::*;

    logic [DW-1:0]     mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;

    // pointer and count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data      = mem_reg[rd_ptr_reg];
    assign stat.can_push = (cnt_reg < QCNT_W'(QUEUE_DEPTH));
    assign stat.has_data = (cnt_reg != '0);

endmodule
`default_nettype wire

@@ rtl/core/crp_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crp_front: tick intake and angle lookup
// Advances the angle counter on each accepted tick, reads sine and cosine
// from a constant table and pushes {sin, cos, scale} into the queue.
// ----------------------------------------------------------------------------
module crp_front #(
    parameter int ANGLE_STEPS    = crp_pkg::ANGLE_STEPS_DEF,
    parameter int TRIG_FRAC_BITS = crp_pkg::TRIG_FRAC_BITS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [crp_pkg::SCALE_W-1:0]   s_scale,
    input  crp_pkg::crp_qstat_t                qstat,
    output logic                               push,
    output logic [2*(TRIG_FRAC_BITS+2)+crp_pkg::SCALE_W-1:0] push_data
);
    import crp_pkg::*;

    localparam int F  = TRIG_FRAC_BITS;
    localparam int TW = F + 2;
    localparam int AW = $clog2(ANGLE_STEPS);
    localparam int SH = 28 - F;
    localparam logic [63:0] PI_Q28 = 64'd843314857;
    localparam logic [63:0] SDIV [1:12] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
        64'd156, 64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600};
    localparam logic [63:0] CDIV [1:12] = '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90,
        64'd132, 64'd182, 64'd240, 64'd306, 64'd380, 64'd462, 64'd552};

    // Q28 value rounded to the table format, halves away from zero
    function automatic logic signed [63:0] rnd28(input logic signed [63:0] v);
        logic [63:0] mag;
        logic [63:0] r;
        mag = v[63] ? 64'(-v) : 64'(v);
        r   = (mag + (64'd1 << (SH - 1))) >> SH;
        return v[63] ? -signed'(r) : signed'(r);
    endfunction

    // sine and cosine of step k from a 13-term series, evaluated at elaboration
    function automatic logic [2*TW-1:0] trig_fn(input int k);
        logic [63:0]        m;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        st;
        logic [63:0]        ct;
        logic signed [63:0] ss;
        logic signed [63:0] cs;
        logic signed [63:0] rs;
        logic signed [63:0] rc;
        logic               neg;
        m   = 64'(k);
        neg = 1'b0;
        if (2 * m > 64'(ANGLE_STEPS)) begin
            m   = 64'(ANGLE_STEPS) - m;
            neg = 1'b1;
        end
        x  = (64'd2 * PI_Q28 * m) / ANGLE_STEPS;
        x2 = (x * x) >> 28;
        st = x;
        ct = 64'd1 << 28;
        ss = signed'(st);
        cs = signed'(ct);
        for (int n = 1; n <= 12; n++) begin
            st = ((st * x2) >> 28) / SDIV[n];
            ct = ((ct * x2) >> 28) / CDIV[n];
            if (n[0]) begin
                ss = ss - signed'(st);
                cs = cs - signed'(ct);
            end else begin
                ss = ss + signed'(st);
                cs = cs + signed'(ct);
            end
        end
        rs = rnd28(ss);
        rc = rnd28(cs);
        return {TW'(neg ? -rs : rs), TW'(rc)};
    endfunction

    // constant trig table
    logic [2*TW-1:0] trig_rom [ANGLE_STEPS];
    for (genvar g = 0; g < ANGLE_STEPS; g++) begin : g_rom
        assign trig_rom[g] = trig_fn(g);
    end

    logic [AW-1:0]      angle_reg;
    logic [AW-1:0]      angle_next;
    logic [SCALE_W-1:0] scale_reg;
    logic [2*TW-1:0]    rom_q_reg;
    logic               look_reg;
    logic               push_reg;
    logic               accept;

    assign s_tready   = !look_reg && !push_reg && qstat.can_push;
    assign accept     = s_tvalid && s_tready;
    assign angle_next = (angle_reg == AW'(ANGLE_STEPS - 1)) ? '0 : angle_reg + 1'b1;

    // control: accept, table read, push
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            angle_reg <= '0;
            look_reg  <= 1'b0;
            push_reg  <= 1'b0;
        end else begin
            look_reg <= accept;
            push_reg <= look_reg;
            if (accept) begin
                angle_reg <= angle_next;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        rom_q_reg <= trig_rom[angle_reg];
        if (accept) begin
            scale_reg <= s_scale;
        end
    end

    assign push      = push_reg;
    assign push_data = {rom_q_reg, scale_reg};

endmodule
`default_nettype wire

@@ rtl/core/crp_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crp_back: vertex rotation and projection sequencer
// For each frame word, walks the eight cube vertices: three rotations on a
// shared pair of multipliers, then a restoring divide per screen axis.
// ----------------------------------------------------------------------------
module crp_back #(
    parameter int TRIG_FRAC_BITS = crp_pkg::TRIG_FRAC_BITS_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  crp_pkg::crp_qstat_t                 qstat,
    input  wire logic [2*(TRIG_FRAC_BITS+2)+crp_pkg::SCALE_W-1:0] pop_data,
    output logic                                pop,
    input  wire logic [crp_pkg::CENTER_W-1:0]   center_x,
    input  wire logic [crp_pkg::CENTER_W-1:0]   center_y,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [crp_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic                                m_tlast
);
    import crp_pkg::*;

    localparam int F  = TRIG_FRAC_BITS;
    localparam int TW = F + 2;
    localparam int CW = F + 3;
    localparam int PW = TW + CW;
    localparam int SW = PW + 1;
    localparam int ZW = F + 9;
    localparam int NW = F + 20;
    localparam int CNT_W = $clog2(QUOT_W);
    localparam logic signed [ZW-1:0] Z_OFF = ZW'(Z_OFFSET) <<< F;
    localparam logic signed [CW-1:0] ONE   = CW'(1) <<< F;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_MUL  = 8'b0000_0010,
        ST_ACC  = 8'b0000_0100,
        ST_PMUL = 8'b0000_1000,
        ST_PSUM = 8'b0001_0000,
        ST_DIV  = 8'b0010_0000,
        ST_FIX  = 8'b0100_0000,
        ST_OUT  = 8'b1000_0000
    } crp_state_t;

    // round a Q2F product sum back to QF, halves away from zero
    function automatic logic signed [CW-1:0] rnd(input logic signed [SW-1:0] v);
        logic [SW-1:0] mag;
        logic [SW-1:0] r;
        mag = v[SW-1] ? SW'(-v) : SW'(v);
        r   = (mag + (SW'(1) << (F - 1))) >> F;
        return v[SW-1] ? -signed'(CW'(r)) : signed'(CW'(r));
    endfunction

    function automatic logic signed [CW-1:0] corner(input logic neg);
        return neg ? -ONE : ONE;
    endfunction

    crp_state_t state_reg, state_next;

    logic [VERT_W-1:0]    vtx_reg;
    logic [1:0]           axis_reg;
    logic                 half_reg;
    logic                 sel_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 out_valid_reg;

    logic signed [TW-1:0] sin_reg, cos_reg;
    logic [SCALE_W-1:0]   scale_reg;
    logic signed [CW-1:0] x_reg, y_reg, z_reg, t_reg;
    logic signed [PW-1:0] p0_reg, p1_reg;
    logic signed [NW-1:0] pc_reg, ps_reg;
    logic [ZW-1:0]        dmag_reg;
    logic [NW-1:0]        rem_reg, dsh_reg;
    logic [QUOT_W-1:0]    q_reg;
    logic                 neg_reg;
    logic [SCREEN_W-1:0]  px_reg, py_reg;
    logic [VERT_W-1:0]    out_vtx_reg;
    logic [SCREEN_W-1:0]  out_x_reg, out_y_reg;
    logic                 out_last_reg;

    // operand selection for the rotation step
    logic signed [CW-1:0] op_u, op_v;
    logic signed [TW-1:0] coef_a, coef_b;
    logic signed [PW-1:0] p0_next, p1_next;
    logic signed [SW-1:0] sum;
    logic signed [CW-1:0] rsum;

    always_comb begin
        case (axis_reg)
            AXIS_X:  begin op_u = y_reg; op_v = z_reg; end
            AXIS_Y:  begin op_u = z_reg; op_v = x_reg; end
            AXIS_Z:  begin op_u = x_reg; op_v = y_reg; end
            default: begin op_u = x_reg; op_v = y_reg; end
        endcase
    end

    assign coef_a  = half_reg ? sin_reg : cos_reg;
    assign coef_b  = half_reg ? cos_reg : sin_reg;
    assign p0_next = PW'(coef_a) * PW'(op_u);
    assign p1_next = PW'(coef_b) * PW'(op_v);
    assign sum     = half_reg ? (SW'(p0_reg) + SW'(p1_reg)) : (SW'(p0_reg) - SW'(p1_reg));
    assign rsum    = rnd(sum);

    // projection operands
    logic signed [ZW-1:0]  zd;
    logic [CENTER_W-1:0]   cen;
    logic signed [CW-1:0]  coord;
    logic signed [NW-1:0]  num;
    logic                  ge;
    logic                  out_free;
    logic                  out_load;

    assign zd       = ZW'(z_reg) - Z_OFF;
    assign cen      = sel_reg ? center_y : center_x;
    assign coord    = sel_reg ? y_reg : x_reg;
    assign num      = pc_reg + ps_reg;
    assign ge       = (rem_reg >= dsh_reg);
    assign out_free = !out_valid_reg || m_tready;
    assign out_load = (state_reg == ST_OUT) && out_free;
    assign pop      = (state_reg == ST_IDLE) && qstat.has_data;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (qstat.has_data) state_next = ST_MUL;
            ST_MUL:  state_next = ST_ACC;
            ST_ACC: begin
                if (!half_reg) begin
                    state_next = ST_MUL;
                end else if (axis_reg == AXIS_Z) begin
                    state_next = ST_PMUL;
                end else begin
                    state_next = ST_MUL;
                end
            end
            ST_PMUL: state_next = ST_PSUM;
            ST_PSUM: state_next = ST_DIV;
            ST_DIV:  if (cnt_reg == '0) state_next = ST_FIX;
            ST_FIX:  state_next = sel_reg ? ST_OUT : ST_PMUL;
            ST_OUT: begin
                if (out_free) begin
                    state_next = (vtx_reg == VERT_W'(NVERT - 1)) ? ST_IDLE : ST_MUL;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            vtx_reg       <= '0;
            axis_reg      <= AXIS_X;
            half_reg      <= 1'b0;
            sel_reg       <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    vtx_reg  <= '0;
                    axis_reg <= AXIS_X;
                    half_reg <= 1'b0;
                    sel_reg  <= 1'b0;
                end
                ST_ACC: begin
                    half_reg <= !half_reg;
                    if (half_reg) begin
                        axis_reg <= axis_reg + 1'b1;
                    end
                end
                ST_PSUM: cnt_reg <= CNT_W'(QUOT_W - 1);
                ST_DIV:  cnt_reg <= cnt_reg - 1'b1;
                ST_FIX:  sel_reg <= !sel_reg;
                ST_OUT: begin
                    if (out_free) begin
                        vtx_reg  <= vtx_reg + 1'b1;
                        axis_reg <= AXIS_X;
                        half_reg <= 1'b0;
                        sel_reg  <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                sin_reg   <= pop_data[SCALE_W+2*TW-1 -: TW];
                cos_reg   <= pop_data[SCALE_W+TW-1 -: TW];
                scale_reg <= pop_data[SCALE_W-1:0];
                x_reg     <= corner(CUBE_X_NEG[0]);
                y_reg     <= corner(CUBE_Y_NEG[0]);
                z_reg     <= corner(CUBE_Z_NEG[0]);
            end
            ST_MUL: begin
                p0_reg <= p0_next;
                p1_reg <= p1_next;
            end
            ST_ACC: begin
                if (!half_reg) begin
                    t_reg <= rsum;
                end else begin
                    case (axis_reg)
                        AXIS_X:  begin y_reg <= t_reg; z_reg <= rsum; end
                        AXIS_Y:  begin z_reg <= t_reg; x_reg <= rsum; end
                        AXIS_Z:  begin x_reg <= t_reg; y_reg <= rsum; end
                        default: ;
                    endcase
                end
            end
            ST_PMUL: begin
                pc_reg   <= NW'(signed'({1'b0, cen})) * NW'(zd);
                ps_reg   <= NW'(coord) * NW'(signed'({1'b0, scale_reg}));
                dmag_reg <= ZW'(-zd);
            end
            ST_PSUM: begin
                neg_reg <= !num[NW-1];
                rem_reg <= num[NW-1] ? NW'(-num) : NW'(num);
                dsh_reg <= NW'(dmag_reg) << (QUOT_W - 1);
                q_reg   <= '0;
            end
            ST_DIV: begin
                if (ge) begin
                    rem_reg <= rem_reg - dsh_reg;
                end
                q_reg   <= {q_reg[QUOT_W-2:0], ge};
                dsh_reg <= dsh_reg >> 1;
            end
            ST_FIX: begin
                if (sel_reg) begin
                    py_reg <= neg_reg ? -q_reg : q_reg;
                end else begin
                    px_reg <= neg_reg ? -q_reg : q_reg;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    x_reg <= corner(CUBE_X_NEG[vtx_reg + 1'b1]);
                    y_reg <= corner(CUBE_Y_NEG[vtx_reg + 1'b1]);
                    z_reg <= corner(CUBE_Z_NEG[vtx_reg + 1'b1]);
                end
            end
            default: ;
        endcase
        if (out_load) begin
            out_vtx_reg  <= vtx_reg;
            out_x_reg    <= px_reg;
            out_y_reg    <= py_reg;
            out_last_reg <= (vtx_reg == VERT_W'(NVERT - 1));
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'({out_y_reg, out_x_reg, out_vtx_reg});
    assign m_tlast  = out_last_reg;

endmodule
`default_nettype wire

@@ rtl/core/cube_rotate_project_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cube_rotate_project_top: rotating cube, perspective projected
// Per frame tick, advances the angle and emits the eight projected cube
// vertices in table order, the eighth marked with tlast.
//
//   channel  dir  word content (low bit up)                 per word
//   s_axis   in   scale[13:0]                               one frame tick
//   m_axis   out  vertex[2:0] screen_x[13:3] screen_y[24:14] one vertex
//   cfg      in   cfg_addr 0 = screen width, 1 = screen height
//
// A tick passes the front through an angle step, a table read and a queue push.
// For each vertex, the back runs the three rotations on its multiplier pair,
// then the two 11-step divides, one per screen axis.
// Two frames may wait in the queue; m_tready low holds the back at a vertex.
// Reset (aresetn, synchronous) clears the angle to 0 and sizes to 240.
// ----------------------------------------------------------------------------
module cube_rotate_project_top #(
    parameter int ANGLE_STEPS    = crp_pkg::ANGLE_STEPS_DEF,
    parameter int TRIG_FRAC_BITS = crp_pkg::TRIG_FRAC_BITS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [crp_pkg::S_TDATA_W-1:0]   s_tdata,    // scale[13:0]
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [crp_pkg::M_TDATA_W-1:0]        m_tdata,    // vertex, screen_x, screen_y
    output logic                                 m_tlast,
    input  wire logic                            cfg_wr_en,
    input  wire logic [crp_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [crp_pkg::CFG_W-1:0]       cfg_wr_data
);
    import crp_pkg::*;

    localparam int DW = 2 * (TRIG_FRAC_BITS + 2) + SCALE_W;

    logic [CFG_W-1:0] width_reg, height_reg;
    crp_qstat_t       qstat;
    logic             push, pop;
    logic [DW-1:0]    push_data, pop_data;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= SCREEN_RESET;
            height_reg <= SCREEN_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_SCREEN_WIDTH:  width_reg  <= cfg_wr_data;
                CFG_SCREEN_HEIGHT: height_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    crp_front #(
        .ANGLE_STEPS    (ANGLE_STEPS),
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_scale   (s_tdata[SCALE_W-1:0]),
        .qstat     (qstat),
        .push      (push),
        .push_data (push_data)
    );

    crp_fifo #(
        .DW (DW)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .stat      (qstat),
        .pop_data  (pop_data)
    );

    crp_back #(
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .qstat    (qstat),
        .pop_data (pop_data),
        .pop      (pop),
        .center_x (width_reg[CFG_W-1:1]),
        .center_y (height_reg[CFG_W-1:1]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
`default_nettype wire

@@ bench/tb_cube_rotate_project_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cube_rotate_project_top: stream bench for the rotating cube projector
// Feeds frame ticks carrying a scale value and computes each projected
// vertex from its own angle counter, trig table and screen size copy.
// Output words are checked field by field in order. The run covers
// several screen sizes, random stalls on both sides, a long output
// stall and a sender pause until the output side has drained.
// ----------------------------------------------------------------------------
module tb_cube_rotate_project_top;
    import crp_pkg::*;

    localparam int  PERIOD     = 12;
    localparam int  STEPS      = ANGLE_STEPS_DEF;
    localparam int  FRAC       = TRIG_FRAC_BITS_DEF;
    localparam int  RUN_LIMIT  = 1000000;
    localparam int  LONG_HOLD  = 3000;
    localparam int  TAIL_WAIT  = 400;
    localparam longint unsigned PI_Q28 = 64'd843314857;

    typedef struct {
        logic [VERT_W-1:0]          vertex;
        logic signed [SCREEN_W-1:0] sx;
        logic signed [SCREEN_W-1:0] sy;
        logic                       last;
    } vertex_word_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;       // scale[13:0]
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;            // vertex[2:0], x[13:3], y[24:14]
    logic                  m_tlast;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_W-1:0]      cfg_wr_data = '0;

    // bench state
    logic [SCALE_W-1:0] tick_q[$];
    vertex_word_t       vertex_q[$];
    longint             sin_tab[STEPS];
    longint             cos_tab[STEPS];
    int                 angle_now = 0;
    logic [CFG_W-1:0]   width_now = SCREEN_RESET;
    logic [CFG_W-1:0]   height_now = SCREEN_RESET;
    int                 send_idle = 0;
    int                 recv_idle = 0;
    logic               hold_req = 1'b0;
    int                 hold_cnt = 0;
    int                 errors = 0;
    int                 cycles = 0;

    cube_rotate_project_top dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    always #(PERIOD / 2) aclk = ~aclk;

    // round right by sh, halves away from zero
    function automatic longint round_off(longint v, int sh);
        longint unsigned mag;
        longint unsigned r;
        mag = (v < 0) ? longint'(-v) : longint'(v);
        r = (mag + (64'd1 << (sh - 1))) >> sh;
        return (v < 0) ? -longint'(r) : longint'(r);
    endfunction

    // Taylor series sine/cosine in Q28, rounded to the trig format
    function automatic void build_trig();
        longint unsigned m, x, x2, st, ct;
        longint ssum, csum;
        logic neg;
        for (int k = 0; k < STEPS; k++) begin
            m = k;
            neg = 1'b0;
            if (2 * m > STEPS) begin
                m = STEPS - m;
                neg = 1'b1;
            end
            x = (2 * PI_Q28 * m) / STEPS;
            x2 = (x * x) >> 28;
            st = x;
            ct = 64'd1 << 28;
            ssum = st;
            csum = ct;
            for (int n = 1; n <= 12; n++) begin
                st = ((st * x2) >> 28) / ((2 * n) * (2 * n + 1));
                ct = ((ct * x2) >> 28) / ((2 * n - 1) * (2 * n));
                if (n % 2) begin
                    ssum -= st;
                    csum -= ct;
                end else begin
                    ssum += st;
                    csum += ct;
                end
            end
            ssum = round_off(ssum, 28 - FRAC);
            sin_tab[k] = neg ? -ssum : ssum;
            cos_tab[k] = round_off(csum, 28 - FRAC);
        end
    endfunction

    // advance the angle, rotate and project all eight corners
    function automatic void predict_frame(logic [SCALE_W-1:0] scale);
        longint one, s, c, sc, cx, cy;
        longint x1, y1, z1, y2, z2, x3, z3, ax, ay, zd, px, py;
        vertex_word_t w;
        one = longint'(1) << FRAC;
        angle_now = (angle_now >= STEPS - 1) ? 0 : angle_now + 1;
        s = sin_tab[angle_now];
        c = cos_tab[angle_now];
        sc = scale;
        cx = width_now >> 1;
        cy = height_now >> 1;
        for (int i = 0; i < NVERT; i++) begin
            x1 = CUBE_X_NEG[i] ? -one : one;
            y1 = CUBE_Y_NEG[i] ? -one : one;
            z1 = CUBE_Z_NEG[i] ? -one : one;
            y2 = round_off(c * y1 - s * z1, FRAC);
            z2 = round_off(s * y1 + c * z1, FRAC);
            x3 = round_off(c * x1 + s * z2, FRAC);
            z3 = round_off(c * z2 - s * x1, FRAC);
            ax = round_off(c * x3 - s * y2, FRAC);
            ay = round_off(s * x3 + c * y2, FRAC);
            zd = z3 - Z_OFFSET * one;
            px = (cx * zd + ax * sc) / zd;
            py = (cy * zd + ay * sc) / zd;
            w.vertex = VERT_W'(i);
            w.sx = px[SCREEN_W-1:0];
            w.sy = py[SCREEN_W-1:0];
            w.last = (i == NVERT - 1);
            vertex_q.push_back(w);
        end
    endfunction

    // input side: ticks accepted at the edge are predicted here
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (aresetn && s_tvalid && s_tready)
            predict_frame(s_tdata[SCALE_W-1:0]);
    end

    // driver: next word offered at the falling edge
    logic s_fire = 1'b0;
    always @(posedge aclk) s_fire <= aresetn & s_tvalid & s_tready;

    always @(negedge aclk) begin
        if (aresetn && (s_fire || !s_tvalid)) begin
            if (tick_q.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
                s_tvalid <= 1'b1;
                s_tdata <= {{(S_TDATA_W - SCALE_W){1'b0}}, tick_q.pop_front()};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: random stalls, plus one long hold-off when requested
    always @(negedge aclk) begin
        if (hold_req && hold_cnt < LONG_HOLD) begin
            hold_cnt <= hold_cnt + 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    // monitor: compare each output word with the oldest prediction
    always @(posedge aclk) begin
        vertex_word_t w;
        if (aresetn && m_tvalid && m_tready) begin
            if (vertex_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected word expected none actual %h last %b",
                         $time, m_tdata, m_tlast);
            end else begin
                w = vertex_q.pop_front();
                if (m_tdata[2:0] !== w.vertex) begin
                    errors++;
                    $display("%0t: vertex expected %0d actual %0d",
                             $time, w.vertex, m_tdata[2:0]);
                end
                if (m_tdata[13:3] !== w.sx) begin
                    errors++;
                    $display("%0t: screen_x v%0d expected %0d actual %0d", $time,
                             w.vertex, w.sx, $signed(m_tdata[13:3]));
                end
                if (m_tdata[24:14] !== w.sy) begin
                    errors++;
                    $display("%0t: screen_y v%0d expected %0d actual %0d", $time,
                             w.vertex, w.sy, $signed(m_tdata[24:14]));
                end
                if (m_tlast !== w.last) begin
                    errors++;
                    $display("%0t: last v%0d expected %b actual %b",
                             $time, w.vertex, w.last, m_tlast);
                end
                if (m_tdata[M_TDATA_W-1:25] !== '0) begin
                    errors++;
                    $display("%0t: pad bits expected 0 actual %h",
                             $time, m_tdata[M_TDATA_W-1:25]);
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (cycles > RUN_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic cfg_write(logic [CFG_ADDR_W-1:0] addr, logic [CFG_W-1:0] data);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= addr;
        cfg_wr_data <= data;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        if (addr == CFG_SCREEN_WIDTH)
            width_now = data;
        else if (addr == CFG_SCREEN_HEIGHT)
            height_now = data;
    endtask

    // wait until every tick is sent and every vertex has come out
    task automatic drain();
        while (tick_q.size() > 0 || s_tvalid || vertex_q.size() > 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic random_ticks(int n);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 3))
                0: tick_q.push_back(SCALE_W'($urandom_range(0, 255)));
                1: tick_q.push_back(SCALE_W'($urandom_range(16000, 16383)));
                default: tick_q.push_back(SCALE_W'($urandom_range(0, 16383)));
            endcase
        end
    endtask

    initial begin
        build_trig();
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: scale extremes and alternating bit patterns at reset size
        tick_q = '{14'd0, 14'd16383, 14'd1, 14'd8192, 14'h2AAA, 14'h1555,
                   14'd100, 14'd16382, 14'd0, 14'd4096};
        drain();

        // widest screen, one-pixel height; writes past the list are ignored
        cfg_write(CFG_SCREEN_WIDTH, 10'd1023);
        cfg_write(CFG_SCREEN_HEIGHT, 10'd1);
        cfg_write(2'd2, 10'h3FF);
        cfg_write(2'd3, 10'h155);
        send_idle = 21;
        recv_idle = 85;
        random_ticks(100);
        drain();

        // zero size; long output hold-off so the input backs up
        cfg_write(CFG_SCREEN_WIDTH, 10'd0);
        cfg_write(CFG_SCREEN_HEIGHT, 10'd0);
        send_idle = 85;
        recv_idle = 21;
        hold_req = 1'b1;
        send_idle = 0;
        random_ticks(10);
        while (hold_cnt < LONG_HOLD) @(posedge aclk);
        send_idle = 85;
        random_ticks(90);
        drain();
        hold_req = 1'b0;

        // random sizes, no idling
        cfg_write(CFG_SCREEN_WIDTH, CFG_W'($urandom_range(1, 1023)));
        cfg_write(CFG_SCREEN_HEIGHT, CFG_W'($urandom_range(1, 1023)));
        send_idle = 0;
        recv_idle = 0;
        random_ticks(90);
        drain();

        // largest square screen
        cfg_write(CFG_SCREEN_WIDTH, 10'd1023);
        cfg_write(CFG_SCREEN_HEIGHT, 10'd1023);
        random_ticks(90);
        drain();

        repeat (TAIL_WAIT) @(posedge aclk);
        if (errors == 0 && vertex_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
